// ===== rtl/core/avcc_ab_pkg.sv =====
// avcc_ab_pkg: shared types and constants of the avcc to annex b converter
// used by the front, queue, back and top-level modules; no dependencies
`timescale 1ns / 1ps

package avcc_ab_pkg;

    // default configuration values for the top-level parameters
    localparam int DEF_LENGTH_FIELD_BYTES = 4;
    localparam int DEF_QUEUE_DEPTH        = 2;

    // start code layout
    localparam int SC_LEN   = 4;
    localparam int SC_IDX_W = $clog2(SC_LEN);
    localparam int BEAT_W   = $clog2(SC_LEN + 1);

    localparam logic [7:0] START_SEQ [SC_LEN] = '{8'h00, 8'h00, 8'h00, 8'h01};

    localparam logic [4:0] TYPE_MASK = 5'h1F;
    localparam logic [4:0] IDR_TYPE  = 5'd5;

    // input op codes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_PARAM  = 1'b1;

    // one unit of work handed from front to back
    typedef struct packed {
        logic       has_start;  // emit a start code first
        logic       has_byte;   // then emit the data byte
        logic       first;      // data byte opens a nal unit
        logic [7:0] data;
    } t_cmd;

endpackage

// ===== rtl/core/avcc_ab_front.sv =====
// avcc_ab_front: accepts input beats, tracks the length / payload phase
// and turns each beat into a command for the queue; uses avcc_ab_pkg
`timescale 1ns / 1ps

module avcc_ab_front #(
    parameter int LENGTH_FIELD_BYTES = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_op,
    input  logic [7:0]        i_in_byte,
    input  logic              i_set_first,
    output logic              o_push,
    output avcc_ab_pkg::t_cmd o_cmd
);
    import avcc_ab_pkg::*;

    localparam int LEN_W  = 8 * LENGTH_FIELD_BYTES;
    localparam int LCNT_W = $clog2(LENGTH_FIELD_BYTES + 1);

    logic [LEN_W-1:0]  r_len_shift, n_len_shift;
    logic [LCNT_W-1:0] r_len_cnt, n_len_cnt;
    logic [LEN_W-1:0]  r_remaining, n_remaining;
    logic              r_expect_first, n_expect_first;

    logic [LEN_W-1:0]  shifted;
    logic              len_phase;
    logic              len_done;

    always_comb begin
        shifted   = LEN_W'({r_len_shift, i_in_byte});
        len_phase = (r_remaining == '0);
        len_done  = (r_len_cnt == LCNT_W'(LENGTH_FIELD_BYTES - 1));

        n_len_shift    = r_len_shift;
        n_len_cnt      = r_len_cnt;
        n_remaining    = r_remaining;
        n_expect_first = r_expect_first;

        o_push         = 1'b0;
        o_cmd.has_start = 1'b0;
        o_cmd.has_byte  = 1'b1;
        o_cmd.first     = 1'b0;
        o_cmd.data      = i_in_byte;

        if (i_accept) begin
            priority if (i_op == OP_PARAM) begin
                o_push          = 1'b1;
                o_cmd.has_start = i_set_first;
                o_cmd.first     = i_set_first;
            end else if (len_phase) begin
                if (len_done) begin
                    // field complete: bare start code, payload count loaded
                    o_push          = 1'b1;
                    o_cmd.has_start = 1'b1;
                    o_cmd.has_byte  = 1'b0;
                    n_remaining     = shifted;
                    n_expect_first  = (shifted != '0);
                    n_len_shift     = '0;
                    n_len_cnt       = '0;
                end else begin
                    n_len_shift = shifted;
                    n_len_cnt   = r_len_cnt + 1'b1;
                end
            end else begin
                o_push         = 1'b1;
                o_cmd.first    = r_expect_first;
                n_expect_first = 1'b0;
                n_remaining    = r_remaining - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_shift    <= '0;
            r_len_cnt      <= '0;
            r_remaining    <= '0;
            r_expect_first <= 1'b0;
        end else begin
            r_len_shift    <= n_len_shift;
            r_len_cnt      <= n_len_cnt;
            r_remaining    <= n_remaining;
            r_expect_first <= n_expect_first;
        end
    end

endmodule

// ===== rtl/core/avcc_ab_queue.sv =====
// avcc_ab_queue: small command fifo between front and back
// uses avcc_ab_pkg for the command type
`timescale 1ns / 1ps

module avcc_ab_queue #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  avcc_ab_pkg::t_cmd i_cmd,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_head_valid,
    output avcc_ab_pkg::t_cmd o_head
);
    import avcc_ab_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_count;

    logic do_push, do_pop;

    assign o_full       = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rptr];
    assign do_push      = i_push && !o_full;
    assign do_pop       = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/core/avcc_ab_back.sv =====
// avcc_ab_back: expands queued commands into output beats, one per cycle
// while the output is not stalled, into a registered output stage; uses avcc_ab_pkg
`timescale 1ns / 1ps

module avcc_ab_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_head_valid,
    input  avcc_ab_pkg::t_cmd i_head,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [7:0]        o_out_byte,
    output logic              o_is_start_code,
    output logic              o_nal_first,
    output logic [4:0]        o_nal_type,
    output logic              o_is_idr,
    output logic              o_last
);
    import avcc_ab_pkg::*;

    logic              r_valid;
    logic              r_busy;
    t_cmd              r_cmd;
    logic [BEAT_W-1:0] r_idx;

    logic [7:0] r_byte;
    logic       r_sc, r_first, r_idr, r_last;
    logic [4:0] r_type;

    t_cmd              src_cmd;
    logic [BEAT_W-1:0] src_idx;
    logic              have, load, sc_beat, beat_last, beat_first;
    logic [7:0]        beat_byte;
    logic [4:0]        beat_type;

    always_comb begin
        src_cmd    = r_busy ? r_cmd : i_head;
        src_idx    = r_busy ? r_idx : '0;
        have       = r_busy || i_head_valid;
        load       = !r_valid || !i_stall;
        sc_beat    = src_cmd.has_start && (src_idx < BEAT_W'(SC_LEN));
        beat_last  = sc_beat ? ((src_idx == BEAT_W'(SC_LEN - 1)) && !src_cmd.has_byte)
                             : 1'b1;
        beat_byte  = sc_beat ? START_SEQ[src_idx[SC_IDX_W-1:0]] : src_cmd.data;
        beat_first = !sc_beat && src_cmd.first;
        beat_type  = beat_first ? (src_cmd.data[4:0] & TYPE_MASK) : 5'd0;
        o_pop      = load && !r_busy && i_head_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_busy  <= 1'b0;
        end else if (load) begin
            r_valid <= have;
            if (have) begin
                r_busy <= !beat_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && have) begin
            r_cmd   <= src_cmd;
            r_idx   <= src_idx + 1'b1;
            r_byte  <= beat_byte;
            r_sc    <= sc_beat;
            r_first <= beat_first;
            r_type  <= beat_type;
            r_idr   <= beat_first && (beat_type == IDR_TYPE);
            r_last  <= beat_last;
        end
    end

    assign o_valid         = r_valid;
    assign o_out_byte      = r_byte;
    assign o_is_start_code = r_sc;
    assign o_nal_first     = r_first;
    assign o_nal_type      = r_type;
    assign o_is_idr        = r_idr;
    assign o_last          = r_last;

endmodule

// ===== rtl/core/avcc_to_annexb_converter_core.sv =====
// avcc_to_annexb_converter_core: top level of the avcc to annex b converter
// instantiates avcc_ab_front, avcc_ab_queue and avcc_ab_back; uses avcc_ab_pkg
`timescale 1ns / 1ps

// Converts an H.264 sample byte stream framed with big-endian length prefixes
// into Annex B form. Each input beat carries one byte; op 0 is sample data,
// op 1 a parameter-set byte. Length bytes are swallowed and, once the field of
// LENGTH_FIELD_BYTES bytes is complete, replaced by the four start-code beats
// 00 00 00 01 (a zero-length unit yields just the start code). Payload bytes
// pass through one beat each, and the first payload byte of a unit is flagged
// with nal_first, its 5-bit type and an IDR mark. A parameter-set byte with
// set_first gets a start code in front of it and is flagged as a unit's first
// byte. o_last marks the final output beat caused by one input beat. Rate: one
// input beat per cycle while the command fifo has room. A unit yields its
// payload length plus four output beats from the single output register of
// the back end. The front end classifies and tracks the length / payload phase,
// the back end expands commands into beats, and a QUEUE_DEPTH command fifo
// lets each side stall on its own; input stall is raised only when that fifo
// is full. No reset sweep is needed: the block is ready right after reset.

module avcc_to_annexb_converter_core #(
    parameter int LENGTH_FIELD_BYTES = avcc_ab_pkg::DEF_LENGTH_FIELD_BYTES,
    parameter int QUEUE_DEPTH        = avcc_ab_pkg::DEF_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,

    // input channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_op,
    input  logic [7:0] i_in_byte,
    input  logic       i_set_first,

    // output channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_is_start_code,
    output logic       o_nal_first,
    output logic [4:0] o_nal_type,
    output logic       o_is_idr,
    output logic       o_last
);
    import avcc_ab_pkg::*;

    logic q_full;
    logic q_head_valid;
    logic q_pop;
    logic fr_push;
    logic in_accept;
    t_cmd fr_cmd;
    t_cmd q_head;

    // input beat is taken whenever the command fifo has room
    assign o_stall   = q_full;
    assign in_accept = i_valid && !q_full;

    avcc_ab_front #(
        .LENGTH_FIELD_BYTES(LENGTH_FIELD_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_op        (i_op),
        .i_in_byte   (i_in_byte),
        .i_set_first (i_set_first),
        .o_push      (fr_push),
        .o_cmd       (fr_cmd)
    );

    avcc_ab_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (fr_push),
        .i_cmd        (fr_cmd),
        .i_pop        (q_pop),
        .o_full       (q_full),
        .o_head_valid (q_head_valid),
        .o_head       (q_head)
    );

    avcc_ab_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head_valid    (q_head_valid),
        .i_head          (q_head),
        .o_pop           (q_pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_byte      (o_out_byte),
        .o_is_start_code (o_is_start_code),
        .o_nal_first     (o_nal_first),
        .o_nal_type      (o_nal_type),
        .o_is_idr        (o_is_idr),
        .o_last          (o_last)
    );

`ifndef SYNTH
    // a command is never pushed into a full fifo
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(fr_push && q_full))
        else $error("command pushed into full queue");

    // start code beats before the closing 01 are emitted without gaps
    a_sc_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_is_start_code && (o_out_byte != 8'h01) && !o_last) |=>
        (o_valid && o_is_start_code))
        else $error("start code burst broken");

    // a start code that is not final is followed by a unit's first byte
    a_sc_then_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_is_start_code && (o_out_byte == 8'h01) && !o_last)
        |=> (o_valid && o_nal_first && !o_is_start_code && o_last))
        else $error("missing first byte after start code");
`endif

endmodule
